/* hdl/rtq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtq_pkg
// shared types, codes and constants of the repeating timer queue
// ----------------------------------------------------------------------------
package rtq_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam logic [31:0] FAST_WINDOW_RESET = 32'd1000;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_POLL   = 2'd1;
   localparam logic [1:0] OP_CANCEL = 2'd2;

   localparam logic [2:0] KIND_FIRE   = 3'd0;
   localparam logic [2:0] KIND_DONE   = 3'd1;
   localparam logic [2:0] KIND_ADDED  = 3'd2;
   localparam logic [2:0] KIND_FULL   = 3'd3;
   localparam logic [2:0] KIND_CANCEL = 3'd4;

   localparam logic [1:0] WAKE_EMPTY = 2'd0;
   localparam logic [1:0] WAKE_FAST  = 2'd1;
   localparam logic [1:0] WAKE_LONG  = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic load_req;    // capture input item
      logic scan_clear;  // start a scan
      logic scan_step;   // examine slot at scan index
      logic use_done;    // scan skips slots already handled this poll
      logic add_write;   // write new timer into free slot
      logic cancel_mark; // mark slot at scan index if owner matches
      logic fire_apply;  // fire or drop best slot
      logic poll_start;  // clear handled bits
      logic set_fast;
      logic clr_fast;
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;   // scan index at last slot
      logic best_found;
      logic best_due;    // best distance <= 0
      logic best_cancel;
      logic free_found;
      logic is_fast;     // best distance below window or not positive
   } stat_type;

endpackage

/* hdl/rtq_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtq_datapath
// slot storage, serial scan for earliest deadline and free slot
// ----------------------------------------------------------------------------
module rtq_datapath import rtq_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT,
   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic        clock,
   input  logic        reset,
   input  ctrl_type    ctrl,
   output stat_type    stat,
   input  logic [7:0]  req_owner_id,
   input  logic [23:0] req_period,
   input  logic [15:0] req_repeat_count,
   input  logic        req_forever_req,
   input  logic [31:0] req_now,
   input  logic [31:0] fast_window,
   output logic [7:0]  best_owner,
   output logic [31:0] best_dist
);

   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [SLOTS-1:0] handled_ff, handled_in;
   logic [SLOTS-1:0] cancel_ff;
   logic [31:0] deadline_ff [SLOTS];
   logic [23:0] period_ff   [SLOTS];
   logic [15:0] remain_ff   [SLOTS];
   logic [SLOTS-1:0] endless_ff;
   logic [7:0]  owner_ff    [SLOTS];
   logic        fast_ff, fast_in;

   logic [7:0]  r_owner_ff;
   logic [23:0] r_period_ff;
   logic [15:0] r_reps_ff;
   logic        r_forever_ff;
   logic [31:0] r_now_ff;

   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] best_ff, best_in;
   logic [31:0]   bdist_ff, bdist_in;
   logic          bfound_ff, bfound_in;
   logic [IW-1:0] free_ff, free_in;
   logic          ffound_ff, ffound_in;

   logic [31:0] cur_dist;
   logic        cand;
   logic [15:0] rem_dec;
   logic        reload;

   assign cur_dist = deadline_ff[idx_ff] - r_now_ff;
   assign cand = valid_ff[idx_ff] && !(ctrl.use_done && handled_ff[idx_ff]);
   assign rem_dec = remain_ff[best_ff] - 16'd1;
   assign reload = endless_ff[best_ff] ||
                   (remain_ff[best_ff] > 16'd1);

   always_comb begin
      idx_in = idx_ff;
      best_in = best_ff;
      bdist_in = bdist_ff;
      bfound_in = bfound_ff;
      free_in = free_ff;
      ffound_in = ffound_ff;
      valid_in = valid_ff;
      handled_in = handled_ff;
      fast_in = fast_ff;
      if (ctrl.scan_clear) begin
         idx_in = '0;
         bfound_in = 1'b0;
         ffound_in = 1'b0;
      end else if (ctrl.scan_step) begin
         if (cand && (!bfound_ff || $signed(cur_dist) < $signed(bdist_ff))) begin
            best_in = idx_ff;
            bdist_in = cur_dist;
            bfound_in = 1'b1;
         end
         if (!valid_ff[idx_ff] && !ffound_ff) begin
            free_in = idx_ff;
            ffound_in = 1'b1;
         end
         if (!stat.scan_last) idx_in = idx_ff + IW'(1);
      end
      if (ctrl.poll_start) handled_in = '0;
      if (ctrl.add_write) valid_in[free_ff] = 1'b1;
      if (ctrl.fire_apply) begin
         handled_in[best_ff] = 1'b1;
         if (cancel_ff[best_ff] || !reload) valid_in[best_ff] = 1'b0;
      end
      if (ctrl.set_fast) fast_in = 1'b1;
      if (ctrl.clr_fast) fast_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fast_ff <= 1'b1;
      end else begin
         valid_ff <= valid_in;
         fast_ff <= fast_in;
      end
      handled_ff <= handled_in;
      idx_ff <= idx_in;
      best_ff <= best_in;
      bdist_ff <= bdist_in;
      bfound_ff <= bfound_in;
      free_ff <= free_in;
      ffound_ff <= ffound_in;
      if (ctrl.load_req) begin
         r_owner_ff <= req_owner_id;
         r_period_ff <= req_period;
         r_reps_ff <= req_repeat_count;
         r_forever_ff <= req_forever_req;
         r_now_ff <= req_now;
      end
      if (ctrl.add_write) begin
         deadline_ff[free_ff] <= r_now_ff + 32'(r_period_ff);
         period_ff[free_ff] <= r_period_ff;
         remain_ff[free_ff] <= r_reps_ff;
         endless_ff[free_ff] <= r_forever_ff;
         cancel_ff[free_ff] <= 1'b0;
         owner_ff[free_ff] <= r_owner_ff;
      end
      if (ctrl.cancel_mark && valid_ff[idx_ff] && owner_ff[idx_ff] == r_owner_ff)
         cancel_ff[idx_ff] <= 1'b1;
      if (ctrl.fire_apply && !cancel_ff[best_ff]) begin
         if (!endless_ff[best_ff] && remain_ff[best_ff] != 16'd0)
            remain_ff[best_ff] <= rem_dec;
         if (reload) deadline_ff[best_ff] <= r_now_ff + 32'(period_ff[best_ff]);
      end
   end

   assign stat.scan_last = (idx_ff == IW'(SLOTS - 1));
   assign stat.best_found = bfound_ff;
   assign stat.best_due = $signed(bdist_ff) <= 0;
   assign stat.best_cancel = cancel_ff[best_ff];
   assign stat.free_found = ffound_ff;
   assign stat.is_fast = ($signed(bdist_ff) <= 0) || (bdist_ff < fast_window);
   assign best_owner = owner_ff[best_ff];
   assign best_dist = bdist_ff;

endmodule

/* hdl/rtq_control.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtq_control
// sequencer for add, cancel and poll, drives the result register
// ----------------------------------------------------------------------------
module rtq_control import rtq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_fired_id,
   output logic [1:0]  rsp_wake_mode,
   output logic [31:0] rsp_wake_delay,
   output logic        rsp_last,
   output ctrl_type    ctrl,
   input  stat_type    stat,
   input  logic [7:0]  best_owner,
   input  logic [31:0] best_dist
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_ADD    = 7'b0000010,
      S_CANCEL = 7'b0000100,
      S_SCAN   = 7'b0001000,
      S_DECIDE = 7'b0010000,
      S_FINAL  = 7'b0100000,
      S_OUT    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic       final_ff, final_in;  // final scan of a poll
   logic       done_ff, done_in;    // return to idle once result taken
   logic       ov_ff, ov_in;
   logic [2:0] ok_ff, ok_in;
   logic [7:0] oid_ff, oid_in;
   logic [1:0] om_ff, om_in;
   logic [31:0] od_ff, od_in;
   logic       ol_ff, ol_in;
   logic       req_acc;

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      final_in = final_ff;
      done_in = done_ff;
      ov_in = ov_ff;
      ok_in = ok_ff; oid_in = oid_ff; om_in = om_ff; od_in = od_ff; ol_in = ol_ff;
      ctrl = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               ctrl.load_req = 1'b1;
               ctrl.scan_clear = 1'b1;
               ctrl.poll_start = 1'b1;
               op_in = req_op;
               final_in = 1'b0;
               case (req_op)
                  OP_ADD:    state_in = S_SCAN;
                  OP_POLL:   state_in = S_SCAN;
                  OP_CANCEL: state_in = S_CANCEL;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_CANCEL: begin
            ctrl.cancel_mark = 1'b1;
            ctrl.scan_step = 1'b1;
            if (stat.scan_last) begin
               ok_in = KIND_CANCEL; oid_in = '0; om_in = WAKE_EMPTY; od_in = '0;
               ol_in = 1'b1; ov_in = 1'b1; done_in = 1'b1;
               state_in = S_OUT;
            end
         end
         S_SCAN: begin
            ctrl.scan_step = 1'b1;
            ctrl.use_done = !final_ff;
            if (stat.scan_last)
               state_in = (op_ff == OP_ADD) ? S_ADD : (final_ff ? S_FINAL : S_DECIDE);
         end
         S_ADD: begin
            ol_in = 1'b1; oid_in = '0; om_in = WAKE_EMPTY; od_in = '0;
            ov_in = 1'b1; done_in = 1'b1;
            if (stat.free_found) begin
               ctrl.add_write = 1'b1;
               ctrl.set_fast = 1'b1;
               ok_in = KIND_ADDED;
            end else begin
               ok_in = KIND_FULL;
            end
            state_in = S_OUT;
         end
         S_DECIDE: begin
            ctrl.scan_clear = 1'b1;
            state_in = S_SCAN;
            if (!stat.best_found || !stat.best_due) begin
               final_in = 1'b1;
            end else begin
               ctrl.fire_apply = 1'b1;
               if (!stat.best_cancel) begin
                  ok_in = KIND_FIRE; oid_in = best_owner; om_in = WAKE_EMPTY;
                  od_in = '0; ol_in = 1'b0; ov_in = 1'b1; done_in = 1'b0;
                  state_in = S_OUT;
               end
            end
         end
         S_FINAL: begin
            ok_in = KIND_DONE; oid_in = '0; ol_in = 1'b1; ov_in = 1'b1;
            done_in = 1'b1; od_in = '0;
            if (!stat.best_found) begin
               om_in = WAKE_EMPTY;
            end else if (stat.is_fast) begin
               om_in = WAKE_FAST;
               ctrl.set_fast = 1'b1;
            end else begin
               om_in = WAKE_LONG;
               od_in = best_dist;
               ctrl.clr_fast = 1'b1;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               ov_in = 1'b0;
               state_in = done_ff ? S_IDLE : S_SCAN;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff <= ov_in;
      end
      op_ff <= op_in;
      final_ff <= final_in;
      done_ff <= done_in;
      ok_ff <= ok_in; oid_ff <= oid_in; om_ff <= om_in; od_ff <= od_in; ol_ff <= ol_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp_kind = ok_ff;
   assign rsp_fired_id = oid_ff;
   assign rsp_wake_mode = om_ff;
   assign rsp_wake_delay = od_ff;
   assign rsp_last = ol_ff;

endmodule

/* hdl/repeating_timer_queue_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// repeating_timer_queue_unit
// queue of repeating software timers with add, cancel and poll
// ----------------------------------------------------------------------------
// req_ carries one operation per transfer (add, poll, cancel); rsp_ returns
// the result items, the final one of each operation flagged by rsp_last.
// csr_ writes the fast window register, which the user must do only while the
// unit is idle; the unit itself does not enforce this. One operation is
// handled at a time; req_stall is high from acceptance until the last result
// transfer has completed and drops once the unit is back in idle.
// Add and cancel each make one serial pass over the slots. Poll makes one
// search pass per due timer, firing it or dropping it if it was cancelled,
// then a last search that finds nothing due and a final scan that closes
// with the done item. A stalled receiver holds the result register and the
// scan waits with it. Reset clears all slot valid bits, the fast flag goes
// to one and the fast window returns to 1000 ticks.
// ----------------------------------------------------------------------------
module repeating_timer_queue_unit import rtq_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_owner_id,
   input  logic [23:0] req_period,
   input  logic [15:0] req_repeat_count,
   input  logic        req_forever_req,
   input  logic [31:0] req_now,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_fired_id,
   output logic [1:0]  rsp_wake_mode,
   output logic [31:0] rsp_wake_delay,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   ctrl_type    ctrl;
   stat_type    stat;
   logic [7:0]  best_owner;
   logic [31:0] best_dist;
   logic [31:0] window_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) window_ff <= FAST_WINDOW_RESET;
      else if (csr_valid && csr_ready) window_ff <= csr_data;
   end

   rtq_control u_control (
      .clock, .reset, .req_valid, .req_stall, .req_op,
      .rsp_valid, .rsp_stall, .rsp_kind, .rsp_fired_id, .rsp_wake_mode,
      .rsp_wake_delay, .rsp_last, .ctrl, .stat, .best_owner, .best_dist
   );

   rtq_datapath #(.SLOTS(SLOTS)) u_datapath (
      .clock, .reset, .ctrl, .stat, .req_owner_id, .req_period,
      .req_repeat_count, .req_forever_req, .req_now,
      .fast_window(window_ff), .best_owner, .best_dist
   );

endmodule

/* hdl/rtq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtq_checker
// port level checks of the timer queue
// ----------------------------------------------------------------------------
module rtq_checker import rtq_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_kind,
   input logic [7:0]  rsp_fired_id,
   input logic [1:0]  rsp_wake_mode,
   input logic [31:0] rsp_wake_delay,
   input logic        rsp_last
);

   // held result must stay valid and keep its kind and last flag
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_last))
      else $error("result changed under stall");

   a_fire_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_FIRE |-> !rsp_last && rsp_wake_mode == WAKE_EMPTY)
      else $error("fire transfer flagged last");

   a_delay_long: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_wake_mode != WAKE_LONG |-> rsp_wake_delay == 32'd0)
      else $error("delay without long mode");

   a_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_FIRE |-> rsp_fired_id == 8'd0)
      else $error("owner id on a non-fire transfer");

   // no new request while a result is pending
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(req_valid && !req_stall))
      else $error("request taken mid operation");

endmodule

bind repeating_timer_queue_unit rtq_checker u_rtq_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_kind,
   .rsp_fired_id, .rsp_wake_mode, .rsp_wake_delay, .rsp_last
);

/* tb/sv/tb_repeating_timer_queue_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_repeating_timer_queue_unit
// self-checking bench for the repeating timer queue
// ----------------------------------------------------------------------------
// A queue of operations feeds a burst driver on req_; a clocked monitor
// predicts the result items of every accepted operation with its own copy of
// the timer slots and the fast window, and checks each rsp_ transfer against
// the oldest prediction. The fast window is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_repeating_timer_queue_unit;
   import rtq_pkg::*;

   localparam int NSLOT = 16;
   localparam logic [1:0] OP_NONE = 2'd3; // unused op code, ignored by the unit

   typedef struct {
      logic [1:0]  op;
      logic [7:0]  owner;
      logic [23:0] period;
      logic [15:0] reps;
      logic        endless;
      logic [31:0] now;
   } timer_op_type;

   typedef struct {
      logic [2:0]  kind;
      logic [7:0]  id;
      logic [1:0]  mode;
      logic [31:0] delay;
      logic        last;
   } timer_rsp_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_op = 0;
   logic [7:0]  req_owner_id = 0;
   logic [23:0] req_period = 0;
   logic [15:0] req_repeat_count = 0;
   logic        req_forever_req = 0;
   logic [31:0] req_now = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_fired_id;
   logic [1:0]  rsp_wake_mode;
   logic [31:0] rsp_wake_delay;
   logic        rsp_last;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [31:0] csr_data = 0;

   repeating_timer_queue_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_owner_id(req_owner_id), .req_period(req_period),
      .req_repeat_count(req_repeat_count), .req_forever_req(req_forever_req),
      .req_now(req_now),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_fired_id(rsp_fired_id), .rsp_wake_mode(rsp_wake_mode),
      .rsp_wake_delay(rsp_wake_delay), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   // predicted timer state
   logic [31:0] win;
   logic        s_valid [NSLOT];
   logic [31:0] s_deadline [NSLOT];
   logic [23:0] s_period [NSLOT];
   logic [15:0] s_remaining [NSLOT];
   logic        s_endless [NSLOT];
   logic        s_cancelled [NSLOT];
   logic [7:0]  s_owner [NSLOT];
   logic        fast_flag;

   timer_op_type  pending_ops [$];
   timer_rsp_type expected_rsp [$];
   int sent_cnt = 0;
   int taken_cnt = 0;
   int errors = 0;

   function automatic timer_rsp_type make_rsp(logic [2:0] k, logic [7:0] id,
                                              logic [1:0] m, logic [31:0] d,
                                              logic l);
      timer_rsp_type r;
      r.kind = k; r.id = id; r.mode = m; r.delay = d; r.last = l;
      return r;
   endfunction

   task automatic predict_timer_op(timer_op_type t);
      logic handled [NSLOT];
      int best;
      logic signed [31:0] bd, d;
      logic reload;
      bit placed;
      case (t.op)
         OP_ADD: begin
            placed = 0;
            for (int i = 0; i < NSLOT; i++) begin
               if (!placed && !s_valid[i]) begin
                  placed = 1;
                  s_valid[i] = 1;
                  s_deadline[i] = t.now + 32'(t.period);
                  s_period[i] = t.period;
                  s_remaining[i] = t.reps;
                  s_endless[i] = t.endless;
                  s_cancelled[i] = 0;
                  s_owner[i] = t.owner;
                  fast_flag = 1;
               end
            end
            expected_rsp.push_back(make_rsp(placed ? KIND_ADDED : KIND_FULL,
                                            0, 0, 0, 1));
         end
         OP_CANCEL: begin
            for (int i = 0; i < NSLOT; i++)
               if (s_valid[i] && s_owner[i] == t.owner) s_cancelled[i] = 1;
            expected_rsp.push_back(make_rsp(KIND_CANCEL, 0, 0, 0, 1));
         end
         OP_POLL: begin
            for (int i = 0; i < NSLOT; i++) handled[i] = 0;
            bd = 0;
            forever begin
               best = -1;
               for (int i = 0; i < NSLOT; i++) begin
                  if (s_valid[i] && !handled[i]) begin
                     d = s_deadline[i] - t.now;
                     if (best < 0 || d < bd) begin
                        best = i; bd = d;
                     end
                  end
               end
               if (best < 0 || bd > 0) break;
               handled[best] = 1;
               if (s_cancelled[best]) begin
                  s_valid[best] = 0;
               end else begin
                  expected_rsp.push_back(make_rsp(KIND_FIRE, s_owner[best], 0, 0, 0));
                  reload = 0;
                  if (s_endless[best]) begin
                     reload = 1;
                  end else if (s_remaining[best] > 0) begin
                     s_remaining[best]--;
                     reload = s_remaining[best] > 0;
                  end
                  if (reload) s_deadline[best] = t.now + 32'(s_period[best]);
                  else s_valid[best] = 0;
               end
            end
            best = -1;
            for (int i = 0; i < NSLOT; i++) begin
               if (s_valid[i]) begin
                  d = s_deadline[i] - t.now;
                  if (best < 0 || d < bd) begin
                     best = i; bd = d;
                  end
               end
            end
            if (best < 0) begin
               expected_rsp.push_back(make_rsp(KIND_DONE, 0, WAKE_EMPTY, 0, 1));
            end else if (bd <= 0 || $unsigned(bd) < win) begin
               fast_flag = 1;
               expected_rsp.push_back(make_rsp(KIND_DONE, 0, WAKE_FAST, 0, 1));
            end else begin
               fast_flag = 0;
               expected_rsp.push_back(make_rsp(KIND_DONE, 0, WAKE_LONG, bd, 1));
            end
         end
         default: ;
      endcase
   endtask

   // request and result monitor
   always @(posedge clock) begin
      timer_op_type t;
      timer_rsp_type e;
      if (!reset && req_valid && !req_stall) begin
         t.op = req_op; t.owner = req_owner_id; t.period = req_period;
         t.reps = req_repeat_count; t.endless = req_forever_req; t.now = req_now;
         predict_timer_op(t);
         taken_cnt++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected result transfer, kind %0d", rsp_kind);
            errors++;
         end else begin
            e = expected_rsp.pop_front();
            if (rsp_kind !== e.kind) begin
               $error("kind: expected %0d, actual %0d", e.kind, rsp_kind); errors++;
            end
            if (rsp_fired_id !== e.id) begin
               $error("fired_id: expected %0d, actual %0d", e.id, rsp_fired_id);
               errors++;
            end
            if (rsp_wake_mode !== e.mode) begin
               $error("wake_mode: expected %0d, actual %0d", e.mode, rsp_wake_mode);
               errors++;
            end
            if (rsp_wake_delay !== e.delay) begin
               $error("wake_delay: expected %0d, actual %0d", e.delay, rsp_wake_delay);
               errors++;
            end
            if (rsp_last !== e.last) begin
               $error("last: expected %0d, actual %0d", e.last, rsp_last); errors++;
            end
         end
      end
   end

   // request driver, bursts with gaps
   int burst_left = 1;
   int gap_left = 0;
   always @(negedge clock) begin
      timer_op_type t;
      if (reset || sent_cnt != taken_cnt) begin
         // payload held until the transfer completes
      end else if (gap_left > 0) begin
         req_valid <= 0;
         gap_left--;
      end else if (pending_ops.size() > 0) begin
         t = pending_ops.pop_front();
         req_valid <= 1;
         req_op <= t.op; req_owner_id <= t.owner; req_period <= t.period;
         req_repeat_count <= t.reps; req_forever_req <= t.endless; req_now <= t.now;
         sent_cnt++;
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         end
      end else begin
         req_valid <= 0;
      end
   end

   // result stall pattern with a randomly chosen mode
   int stall_cyc = 0;
   int stall_mode = 0;
   always @(negedge clock) begin
      stall_cyc++;
      if (stall_cyc % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 0;
         1: rsp_stall <= $urandom_range(0, 1);
         2: rsp_stall <= (stall_cyc % 16) < 10;
         default: rsp_stall <= ($urandom_range(0, 7) == 0);
      endcase
   end

   task automatic add_op(logic [1:0] op, logic [7:0] owner, logic [23:0] period,
                         logic [15:0] reps, logic endless, logic [31:0] now);
      timer_op_type t;
      t.op = op; t.owner = owner; t.period = period; t.reps = reps;
      t.endless = endless; t.now = now;
      pending_ops.push_back(t);
   endtask

   task automatic wait_quiet();
      while (pending_ops.size() != 0 || sent_cnt != taken_cnt ||
             expected_rsp.size() != 0)
         @(posedge clock);
      // an ignored op leaves no result to wait for, so let the unit settle
      repeat (60) @(posedge clock);
   endtask

   task automatic write_window(logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      win = value;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic queue_random_ops(int count, inout logic [31:0] tnow);
      int r;
      logic [7:0] owner;
      logic [23:0] period;
      logic [15:0] reps;
      for (int n = 0; n < count; n++) begin
         tnow += $urandom_range(0, 3000);
         owner = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 7));
         r = $urandom_range(0, 99);
         if (r < 3) period = 0;
         else if (r < 8) period = 24'($urandom_range(1, 24'hFFFFFF));
         else period = 24'($urandom_range(1, 4000));
         reps = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 16'hFFFF))
                                            : 16'($urandom_range(0, 4));
         r = $urandom_range(0, 99);
         add_op(r < 40 ? OP_ADD : r < 80 ? OP_POLL : r < 96 ? OP_CANCEL : OP_NONE,
                owner, period, reps, $urandom_range(0, 3) == 0,
                ($urandom_range(0, 19) == 0) ? $urandom() : tnow);
      end
   endtask

   initial begin
      logic [31:0] tnow;
      win = FAST_WINDOW_RESET;
      fast_flag = 1;
      for (int i = 0; i < NSLOT; i++) begin
         s_valid[i] = 0; s_deadline[i] = 0; s_period[i] = 0; s_remaining[i] = 0;
         s_endless[i] = 0; s_cancelled[i] = 0; s_owner[i] = 0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: extremes, wraparound, period zero, cancel drop, full queue
      add_op(OP_ADD, 8'd0, 24'd1, 16'd0, 1'b0, 32'd0);
      add_op(OP_ADD, 8'hFF, 24'hFFFFFF, 16'hFFFF, 1'b1, 32'd0);
      add_op(OP_ADD, 8'd7, 24'd0, 16'd1, 1'b0, 32'd0);
      add_op(OP_POLL, 8'd0, 24'd0, 16'd0, 1'b0, 32'd0);
      add_op(OP_POLL, 8'd0, 24'd0, 16'd0, 1'b0, 32'd1);
      add_op(OP_CANCEL, 8'hFF, 24'd0, 16'd0, 1'b0, 32'd1);
      add_op(OP_POLL, 8'd0, 24'd0, 16'd0, 1'b0, 32'h00FF_FFFF);
      add_op(OP_ADD, 8'd3, 24'd5000, 16'd3, 1'b0, 32'hFFFF_FFF0);
      add_op(OP_POLL, 8'd0, 24'd0, 16'd0, 1'b0, 32'hFFFF_FFF0);
      add_op(OP_NONE, 8'hAA, 24'hFFFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
      for (int i = 0; i < 15; i++)
         add_op(OP_ADD, 8'(i + 16), 24'(i + 2), 16'(i % 3), i == 4, 32'hFFFF_FFF0);
      add_op(OP_ADD, 8'd99, 24'd1, 16'd1, 1'b0, 32'hFFFF_FFF0);
      add_op(OP_POLL, 8'd0, 24'd0, 16'd0, 1'b0, 32'd100);
      wait_quiet();

      tnow = 32'd200;
      write_window(32'd1);
      queue_random_ops(60, tnow);
      wait_quiet();
      write_window(32'hFFFF_FFFF);
      queue_random_ops(60, tnow);
      wait_quiet();
      write_window(32'd0);
      queue_random_ops(20, tnow);
      wait_quiet();
      write_window(32'd2500);
      queue_random_ops(43, tnow);
      wait_quiet();

      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         if (expected_rsp.size() != 0)
            $error("%0d expected results never arrived", expected_rsp.size());
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

/* files.f */
hdl/rtq_pkg.sv
hdl/rtq_datapath.sv
hdl/rtq_control.sv
hdl/repeating_timer_queue_unit.sv
hdl/rtq_checker.sv
tb/sv/tb_repeating_timer_queue_unit.sv
